// ===== hw/rtl/date_time_string_validator_assert.svh =====
// Assertion macros for the date and time string validator.
// Used by the top level; expects signals clk and arst_n in scope.
`ifndef DATE_TIME_STRING_VALIDATOR_ASSERT_SVH
`define DATE_TIME_STRING_VALIDATOR_ASSERT_SVH

// same-cycle implication
`define DTSV_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("date_time_string_validator: assertion failed");

// next-cycle implication
`define DTSV_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("date_time_string_validator: assertion failed");

`endif

// ===== hw/rtl/dtsv_pkg.sv =====
// Shared types, constants and the layout table of the date and time string validator.
// No dependencies.
package dtsv_pkg;

	localparam int YEAR_W = 14;
	localparam int FIELD_W = 7;
	localparam int POS_W = 5;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [YEAR_W-1:0] YEAR_LOW_RST = 14'd1900;
	localparam logic [YEAR_W-1:0] YEAR_HIGH_RST = 14'd2030;

	localparam logic [FIELD_W-1:0] MONTH_MAX = 7'd12;
	localparam logic [FIELD_W-1:0] DAY_MAX = 7'd31;
	localparam logic [FIELD_W-1:0] HOUR_MAX = 7'd23;
	localparam logic [FIELD_W-1:0] MINSEC_MAX = 7'd59;

	localparam logic [POS_W-1:0] POS_MAX = 5'd31;

	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [1:0] MODE_DATE = 2'd0;
	localparam logic [1:0] MODE_TIME = 2'd1;
	localparam logic [1:0] MODE_BOTH = 2'd2;
	localparam logic [1:0] MODE_NONE = 2'd3;

	localparam logic [POS_W-1:0] LEN_DATE = 5'd10;
	localparam logic [POS_W-1:0] LEN_TIME = 5'd8;
	localparam logic [POS_W-1:0] LEN_BOTH = 5'd19;
	localparam logic [POS_W-1:0] OFS_TIME = 5'd11;

	localparam logic REG_YEAR_LOW = 1'b0;
	localparam logic REG_YEAR_HIGH = 1'b1;

	typedef enum logic [3:0] {
		K_YEAR, K_MONTH, K_DAY, K_HOUR, K_MINUTE, K_SECOND,
		K_SLASH, K_COLON, K_SPACE
	} layout_kind_t;

	typedef struct packed {
		logic [7:0] ch;
		logic [1:0] mode;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic               valid_res;
		logic [YEAR_W-1:0]  year;
		logic [FIELD_W-1:0] month;
		logic [FIELD_W-1:0] day;
		logic [FIELD_W-1:0] hour;
		logic [FIELD_W-1:0] minute;
		logic [FIELD_W-1:0] second;
	} out_item_t;

	// combined layout YYYY/MM/DD hh:mm:ss
	function automatic layout_kind_t layout_kind(input logic [POS_W-1:0] idx);
		layout_kind_t k;
		case (idx)
			5'd0, 5'd1, 5'd2, 5'd3: k = K_YEAR;
			5'd4, 5'd7:             k = K_SLASH;
			5'd5, 5'd6:             k = K_MONTH;
			5'd8, 5'd9:             k = K_DAY;
			5'd10:                  k = K_SPACE;
			5'd11, 5'd12:           k = K_HOUR;
			5'd13, 5'd16:           k = K_COLON;
			5'd14, 5'd15:           k = K_MINUTE;
			default:                k = K_SECOND;
		endcase
		return k;
	endfunction

	function automatic logic [YEAR_W-1:0] acc_year(input logic [YEAR_W-1:0] acc,
			input logic [3:0] d);
		logic [YEAR_W-1:0] s;
		s = (acc << 3) + (acc << 1) + {{(YEAR_W-4){1'b0}}, d};
		return s;
	endfunction

	function automatic logic [FIELD_W-1:0] acc_field(input logic [FIELD_W-1:0] acc,
			input logic [3:0] d);
		logic [FIELD_W-1:0] s;
		s = (acc << 3) + (acc << 1) + {{(FIELD_W-4){1'b0}}, d};
		return s;
	endfunction

endpackage

// ===== hw/rtl/dtsv_parse.sv =====
// Per-string parser state: position, mode, format flag and field accumulators.
// Depends on dtsv_pkg.
module dtsv_parse (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  dtsv_pkg::in_item_t            item,
	input  logic [dtsv_pkg::YEAR_W-1:0]   year_low,
	input  logic [dtsv_pkg::YEAR_W-1:0]   year_high,
	output dtsv_pkg::out_item_t           result
);

	logic [dtsv_pkg::POS_W-1:0]   position_q;
	logic                         format_bad_q;
	logic [1:0]                   mode_q;
	logic [dtsv_pkg::YEAR_W-1:0]  year_q;
	logic [dtsv_pkg::FIELD_W-1:0] month_q, day_q, hour_q, minute_q, second_q;

	logic [1:0]                   md;
	logic [dtsv_pkg::POS_W-1:0]   len, offset, lay_idx;
	dtsv_pkg::layout_kind_t       kind;
	logic                         in_range, is_dig, is_sep, sep_ok, bad_nx;
	logic [3:0]                   d;
	logic [dtsv_pkg::YEAR_W-1:0]  year_nx;
	logic [dtsv_pkg::FIELD_W-1:0] month_nx, day_nx, hour_nx, minute_nx, second_nx;
	logic                         ok, has_date, has_time, date_ok, time_ok;

	always_comb begin
		md = (position_q == '0) ? item.mode : mode_q;
		unique case (md)
			dtsv_pkg::MODE_DATE: begin
				len = dtsv_pkg::LEN_DATE;
				offset = '0;
			end
			dtsv_pkg::MODE_TIME: begin
				len = dtsv_pkg::LEN_TIME;
				offset = dtsv_pkg::OFS_TIME;
			end
			dtsv_pkg::MODE_BOTH: begin
				len = dtsv_pkg::LEN_BOTH;
				offset = '0;
			end
			default: begin
				len = '0;
				offset = '0;
			end
		endcase
		in_range = position_q < len;
		lay_idx = offset + position_q;
		kind = dtsv_pkg::layout_kind(lay_idx);
		is_dig = (item.ch >= dtsv_pkg::CH_ZERO) && (item.ch <= dtsv_pkg::CH_NINE);
		d = item.ch[3:0];
		is_sep = 1'b0;
		sep_ok = 1'b0;
		unique case (kind)
			dtsv_pkg::K_SLASH: begin
				is_sep = 1'b1;
				sep_ok = item.ch == dtsv_pkg::CH_SLASH;
			end
			dtsv_pkg::K_COLON: begin
				is_sep = 1'b1;
				sep_ok = item.ch == dtsv_pkg::CH_COLON;
			end
			dtsv_pkg::K_SPACE: begin
				is_sep = 1'b1;
				sep_ok = item.ch == dtsv_pkg::CH_SPACE;
			end
			default: begin
				is_sep = 1'b0;
				sep_ok = 1'b0;
			end
		endcase
		bad_nx = format_bad_q | !in_range | (is_sep ? !sep_ok : !is_dig);

		year_nx = year_q;
		month_nx = month_q;
		day_nx = day_q;
		hour_nx = hour_q;
		minute_nx = minute_q;
		second_nx = second_q;
		if (in_range && !is_sep && is_dig) begin
			unique case (kind)
				dtsv_pkg::K_YEAR:   year_nx = dtsv_pkg::acc_year(year_q, d);
				dtsv_pkg::K_MONTH:  month_nx = dtsv_pkg::acc_field(month_q, d);
				dtsv_pkg::K_DAY:    day_nx = dtsv_pkg::acc_field(day_q, d);
				dtsv_pkg::K_HOUR:   hour_nx = dtsv_pkg::acc_field(hour_q, d);
				dtsv_pkg::K_MINUTE: minute_nx = dtsv_pkg::acc_field(minute_q, d);
				default:            second_nx = dtsv_pkg::acc_field(second_q, d);
			endcase
		end

		has_date = (md == dtsv_pkg::MODE_DATE) || (md == dtsv_pkg::MODE_BOTH);
		has_time = (md == dtsv_pkg::MODE_TIME) || (md == dtsv_pkg::MODE_BOTH);
		date_ok = (year_nx >= year_low) && (year_nx <= year_high) &&
			(month_nx != '0) && (month_nx <= dtsv_pkg::MONTH_MAX) &&
			(day_nx != '0) && (day_nx <= dtsv_pkg::DAY_MAX);
		time_ok = (hour_nx <= dtsv_pkg::HOUR_MAX) && (minute_nx <= dtsv_pkg::MINSEC_MAX) &&
			(second_nx <= dtsv_pkg::MINSEC_MAX);
		ok = !bad_nx && (len != '0) && ((position_q + 5'd1) == len) &&
			(!has_date || date_ok) && (!has_time || time_ok);

		result = '0;
		result.valid_res = ok;
		if (ok && has_date) begin
			result.year = year_nx;
			result.month = month_nx;
			result.day = day_nx;
		end
		if (ok && has_time) begin
			result.hour = hour_nx;
			result.minute = minute_nx;
			result.second = second_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			format_bad_q <= 1'b0;
			mode_q <= '0;
			year_q <= '0;
			month_q <= '0;
			day_q <= '0;
			hour_q <= '0;
			minute_q <= '0;
			second_q <= '0;
		end else if (fire) begin
			if (item.last) begin
				position_q <= '0;
				format_bad_q <= 1'b0;
				mode_q <= '0;
				year_q <= '0;
				month_q <= '0;
				day_q <= '0;
				hour_q <= '0;
				minute_q <= '0;
				second_q <= '0;
			end else begin
				if (position_q != dtsv_pkg::POS_MAX) position_q <= position_q + 5'd1;
				format_bad_q <= bad_nx;
				mode_q <= md;
				year_q <= year_nx;
				month_q <= month_nx;
				day_q <= day_nx;
				hour_q <= hour_nx;
				minute_q <= minute_nx;
				second_q <= second_nx;
			end
		end
	end

endmodule

// ===== hw/rtl/date_time_string_validator.sv =====
// Top level of the date and time string validator: handshakes, APB registers, result register.
// Depends on dtsv_pkg, dtsv_parse and date_time_string_validator_assert.svh.
//
//   channel | signals                                   | transaction
//   input   | in_valid, in_stall, in_data               | one character
//   output  | out_valid, out_stall, out_data            | one result per string
//   config  | psel, penable, pwrite, paddr, pwdata, ... | year_low at 0, year_high at 4
//
// One character per cycle while in_stall is low; the result of a string is registered.
// Path: input register, parser logic, result register.
// Reset restores the year window 1900..2030 and clears the string state.
// A stalled result holds; input stalls only when a last character meets a full stalled result.
`include "date_time_string_validator_assert.svh"

module date_time_string_validator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  dtsv_pkg::in_item_t            in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output dtsv_pkg::out_item_t           out_data,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dtsv_pkg::ADDR_W-1:0]   paddr,
	input  logic [dtsv_pkg::DATA_W-1:0]   pwdata,
	output logic [dtsv_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	logic [dtsv_pkg::YEAR_W-1:0] year_low_q, year_high_q;
	logic                        valid_s1;
	dtsv_pkg::in_item_t          item_s1;
	logic                        advance, in_fire;
	dtsv_pkg::out_item_t         result;

	assign pready = 1'b1;

	always_comb begin
		unique case (paddr[2])
			dtsv_pkg::REG_YEAR_LOW:  prdata = {{(dtsv_pkg::DATA_W-dtsv_pkg::YEAR_W){1'b0}},
				year_low_q};
			default:                 prdata = {{(dtsv_pkg::DATA_W-dtsv_pkg::YEAR_W){1'b0}},
				year_high_q};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_low_q <= dtsv_pkg::YEAR_LOW_RST;
			year_high_q <= dtsv_pkg::YEAR_HIGH_RST;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == dtsv_pkg::REG_YEAR_LOW) year_low_q <= pwdata[dtsv_pkg::YEAR_W-1:0];
			else year_high_q <= pwdata[dtsv_pkg::YEAR_W-1:0];
		end
	end

	assign advance = valid_s1 && !(item_s1.last && out_valid && out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_fire = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) item_s1 <= in_data;
	end

	dtsv_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (advance),
		.item      (item_s1),
		.year_low  (year_low_q),
		.year_high (year_high_q),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance && item_s1.last) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.last) out_data <= result;
	end

	`DTSV_ASSERT_NOW(a_stall_cause, in_stall,
		valid_s1 && item_s1.last && out_valid && out_stall)
	`DTSV_ASSERT_NEXT(a_result_loaded, advance && item_s1.last, out_valid)
	`DTSV_ASSERT_NOW(a_invalid_zero, out_valid && !out_data.valid_res,
		out_data.year == '0 && out_data.month == '0 && out_data.day == '0 &&
		out_data.hour == '0 && out_data.minute == '0 && out_data.second == '0)

endmodule
